/* hdl/gmevs_pkg.sv */
`default_nettype none
package gmevs_pkg;
	localparam int MAX_WIDTH_DEF = 64;
	localparam int MAX_HEIGHT_DEF = 64;
	localparam int PIX_W = 24;
	localparam int EN_W = 19;
	localparam int TOT_W = 25;
	localparam int CFG_W = 7;
	localparam logic CFG_IDX_WIDTH = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	// Squared absolute difference of two 8-bit channels.
	function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? a - b : b - a;
		return 16'(d * d);
	endfunction

	// Sum of the three channel terms of one neighbor pair.
	function automatic logic [17:0] pair_cost(input logic [23:0] a, input logic [23:0] b);
		return 18'(chan_sq(a[23:16], b[23:16])) + 18'(chan_sq(a[15:8], b[15:8]))
			+ 18'(chan_sq(a[7:0], b[7:0]));
	endfunction
endpackage
`default_nettype wire

/* hdl/gmevs_ram.sv */
`default_nettype none
module gmevs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hdl/gmevs_front.sv */
`default_nettype none
module gmevs_front #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64,
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [7:0]           red,
	input  wire logic [7:0]           green,
	input  wire logic [7:0]           blue,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire logic [6:0]           cfg_data,
	input  wire logic                 back_busy,
	output logic                      busy,
	output logic                      pix_we,
	output logic [AW-1:0]             pix_addr,
	output logic [23:0]               pix_data,
	output logic                      frame_go,
	output logic [XW:0]               w_out,
	output logic [YW:0]               h_out
);
	import gmevs_pkg::*;

	logic [6:0] wreg_q, hreg_q;
	logic [XW:0] x_q;
	logic [YW:0] y_q;
	logic go_q;

	// Clamp the register values to 1..MAX.
	always_comb begin
		if (wreg_q == 7'd0) w_out = (XW+1)'(1);
		else if (32'(wreg_q) > MAX_WIDTH) w_out = (XW+1)'(MAX_WIDTH);
		else w_out = (XW+1)'(wreg_q);
		if (hreg_q == 7'd0) h_out = (YW+1)'(1);
		else if (32'(hreg_q) > MAX_HEIGHT) h_out = (YW+1)'(MAX_HEIGHT);
		else h_out = (YW+1)'(hreg_q);
	end

	assign cfg_ready = 1'b1;
	assign busy = back_busy | go_q;
	assign pix_we = start & ~busy;
	assign pix_addr = AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
	assign pix_data = {red, green, blue};
	assign frame_go = go_q;

	// Pixel position counter; the last pixel of a frame hands off to the back part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wreg_q <= 7'd64;
			hreg_q <= 7'd64;
			x_q <= '0;
			y_q <= '0;
			go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_IDX_WIDTH) wreg_q <= cfg_data;
				else hreg_q <= cfg_data;
				x_q <= '0;
				y_q <= '0;
			end else if (pix_we) begin
				if (x_q + 1'b1 == w_out) begin
					x_q <= '0;
					if (y_q + 1'b1 == h_out) begin
						y_q <= '0;
						go_q <= 1'b1;
					end else begin
						y_q <= y_q + 1'b1;
					end
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/gmevs_back.sv */
`default_nettype none
module gmevs_back #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64,
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          frame_go,
	input  wire logic [XW:0]   w_in,
	input  wire logic [YW:0]   h_in,
	output logic               busy,
	output logic [AW-1:0]      raddr,
	input  wire logic [23:0]   rdata,
	output logic               done,
	output logic [5:0]         seam_row,
	output logic [5:0]         seam_column,
	output logic [24:0]        seam_total,
	output logic               last
);
	import gmevs_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ERD   = 7'b0000010,
		S_EWR   = 7'b0000100,
		S_TRD   = 7'b0001000,
		S_TSTEP = 7'b0010000,
		S_COPY  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t st_q;
	logic [XW:0] w_q;
	logic [YW:0] h_q;
	logic [XW-1:0] x_q, sc_q, col_q;
	logic [YW-1:0] y_q;
	logic [2:0] k_q;
	logic [23:0] nb_q [4];
	logic [EN_W-1:0] cand_q [3];
	logic [TOT_W-1:0] trial_q, best_q;
	logic sel_q;
	logic out_v_s1;
	logic [5:0] row_s1;
	logic last_s1;

	// Energy map RAM.
	logic e_we;
	logic [AW-1:0] e_waddr, e_raddr;
	logic [EN_W-1:0] e_wdata, e_rdata;
	gmevs_ram #(.WIDTH(EN_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_emap (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	function automatic logic [AW-1:0] adr(input logic [XW-1:0] xx, input logic [YW-1:0] yy);
		return AW'(32'(yy) * MAX_WIDTH + 32'(xx));
	endfunction

	logic [XW-1:0] xl, xr, cl, cr;
	logic [YW-1:0] yu, yd;
	logic [YW-1:0] hm1;
	logic [XW-1:0] wm1;
	assign wm1 = XW'(w_q - 1'b1);
	assign hm1 = YW'(h_q - 1'b1);
	assign xl = (x_q == '0) ? wm1 : x_q - 1'b1;
	assign xr = (x_q == wm1) ? '0 : x_q + 1'b1;
	assign yu = (y_q == '0) ? hm1 : y_q - 1'b1;
	assign yd = (y_q == hm1) ? '0 : y_q + 1'b1;
	assign cl = col_q - 1'b1;
	assign cr = col_q + 1'b1;

	// Pixel read address: four neighbors per energy point.
	always_comb begin
		case (k_q[1:0])
			2'd0: raddr = adr(xl, y_q);
			2'd1: raddr = adr(xr, y_q);
			2'd2: raddr = adr(x_q, yu);
			default: raddr = adr(x_q, yd);
		endcase
	end

	// Energy read address: down, right, left candidates of the next row.
	always_comb begin
		case (k_q[1:0])
			2'd0: e_raddr = adr(col_q, y_q);
			2'd1: e_raddr = adr(cr, y_q);
			default: e_raddr = adr(cl, y_q);
		endcase
	end

	logic [17:0] ex, ey;
	assign ex = (w_q > 1) ? pair_cost(nb_q[0], nb_q[1]) : '0;
	assign ey = (h_q > 1) ? pair_cost(nb_q[2], nb_q[3]) : '0;
	assign e_we = (st_q == S_EWR);
	assign e_waddr = adr(x_q, y_q);
	assign e_wdata = EN_W'(ex) + EN_W'(ey);

	// Greedy pick with the down, right, left tie order.
	logic [XW-1:0] pick;
	logic [EN_W-1:0] pbest;
	always_comb begin
		pick = col_q;
		pbest = cand_q[0];
		if (32'(col_q) + 1 < 32'(w_q) && cand_q[1] < pbest) begin
			pick = cr;
			pbest = cand_q[1];
		end
		if (col_q != '0 && cand_q[2] < pbest) begin
			pick = cl;
			pbest = cand_q[2];
		end
	end

	// Seam column RAM with two banks; sel_q names the bank that holds the best seam,
	// the trial seam goes into the other one.
	logic c_we;
	logic [YW:0] c_waddr, c_raddr;
	logic [XW-1:0] c_wdata, c_rdata;
	gmevs_ram #(.WIDTH(XW), .DEPTH(2 * MAX_HEIGHT)) u_cols (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);
	assign c_we = (st_q == S_TSTEP);
	assign c_waddr = {~sel_q, y_q};
	assign c_wdata = (y_q == '0) ? col_q : pick;
	assign c_raddr = {sel_q, y_q};

	assign busy = (st_q != S_IDLE) | out_v_s1;
	assign done = out_v_s1;
	assign seam_row = row_s1;
	assign seam_column = 6'(c_rdata);
	assign seam_total = best_q;
	assign last = last_s1;

	// Result stage, aligned with the registered column read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1 <= 1'b0;
			row_s1 <= '0;
			last_s1 <= 1'b0;
		end else begin
			out_v_s1 <= (st_q == S_OUT);
			row_s1 <= 6'(y_q);
			last_s1 <= (y_q == hm1);
		end
	end

	// Sequencer: energy pass, seam trials, then one result per row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= '0;
			x_q <= '0;
			y_q <= '0;
			sc_q <= '0;
			col_q <= '0;
			w_q <= '0;
			h_q <= '0;
			trial_q <= '0;
			best_q <= '0;
			sel_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (frame_go) begin
						w_q <= w_in;
						h_q <= h_in;
						x_q <= '0;
						y_q <= '0;
						k_q <= '0;
						st_q <= S_ERD;
					end
				end
				S_ERD: begin
					// Read data arrives in the cycle after its address.
					if (k_q != 3'd0) nb_q[k_q[1:0] - 2'd1] <= rdata;
					if (k_q == 3'd4) begin
						st_q <= S_EWR;
					end
					k_q <= k_q + 1'b1;
				end
				S_EWR: begin
					k_q <= '0;
					st_q <= S_ERD;
					if (x_q == wm1) begin
						x_q <= '0;
						if (y_q == hm1) begin
							y_q <= '0;
							sc_q <= '0;
							st_q <= S_TRD;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						x_q <= x_q + 1'b1;
					end
					if (x_q == wm1 && y_q == hm1) begin
						col_q <= '0;
					end
				end
				S_TRD: begin
					// Row 0 uses only the down slot; every row reads three candidates.
					if (k_q != 3'd0) cand_q[k_q[1:0] - 2'd1] <= e_rdata;
					if (k_q == 3'd3) begin
						k_q <= '0;
						st_q <= S_TSTEP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_TSTEP: begin
					if (y_q == '0) begin
						trial_q <= TOT_W'(cand_q[0]);
					end else begin
						trial_q <= trial_q + TOT_W'(pbest);
						col_q <= pick;
					end
					if (y_q == hm1) begin
						y_q <= '0;
						st_q <= S_COPY;
					end else begin
						y_q <= y_q + 1'b1;
						st_q <= S_TRD;
					end
				end
				S_COPY: begin
					// The first trial, or a strictly better one, takes over by swapping banks.
					if (sc_q == '0 || trial_q < best_q) begin
						best_q <= trial_q;
						sel_q <= ~sel_q;
					end
					if (sc_q == wm1) begin
						y_q <= '0;
						st_q <= S_OUT;
					end else begin
						sc_q <= sc_q + 1'b1;
						col_q <= sc_q + 1'b1;
						y_q <= '0;
						st_q <= S_TRD;
					end
				end
				S_OUT: begin
					if (y_q == hm1) begin
						y_q <= '0;
						st_q <= S_IDLE;
					end else begin
						y_q <= y_q + 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/greedy_min_energy_vertical_seam.sv */
`default_nettype none
// Pixels are taken one per cycle while busy is low; the frame's last pixel starts the search
// through a registered hand-off. Energy: four neighbor reads, then a write, per pixel.
// Seam trials: per start column, three candidate reads and a step per row, then a compare.
// Results: one per row, one per cycle with done high; the receiver cannot stall the results.
// busy stays high from the cycle after the last pixel until the last result has gone out.
// Reset clears control state and sets both size registers to 64; stores are undefined.
module greedy_min_energy_vertical_seam #(
	parameter int MAX_WIDTH = gmevs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gmevs_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data,
	output logic             done,
	output logic [5:0]       seam_row,
	output logic [5:0]       seam_column,
	output logic [24:0]      seam_total,
	output logic             last
);
	import gmevs_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);

	logic back_busy, pix_we, frame_go;
	logic [AW-1:0] pix_addr, raddr;
	logic [23:0] pix_data, rdata;
	logic [XW:0] w;
	logic [YW:0] h;

	gmevs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .start, .red, .green, .blue, .cfg_valid, .cfg_ready, .cfg_index,
		.cfg_data, .back_busy, .busy, .pix_we, .pix_addr, .pix_data, .frame_go,
		.w_out(w), .h_out(h)
	);

	// Frame store.
	gmevs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_pix (
		.clk, .we(pix_we), .waddr(pix_addr), .wdata(pix_data), .raddr, .rdata
	);

	gmevs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk, .arst_n, .frame_go, .w_in(w), .h_in(h), .busy(back_busy), .raddr, .rdata,
		.done, .seam_row, .seam_column, .seam_total, .last
	);
endmodule
`default_nettype wire
